// ===== design/pcbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcbp_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN_DEF = 32;

    localparam int CMD_W   = 2;
    localparam int SYM_W   = 8;
    localparam int WORD_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int ACC_W   = BYTE_W - 1;
    localparam int TDATA_W = 48;
    localparam int CNT_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] count;
    } t_emit_req;

endpackage

`default_nettype wire

// ===== design/pcbp_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcbp_table #(
    parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_wr_en,
    input  wire logic [$clog2(SYMBOL_COUNT)-1:0]   i_wr_addr,
    input  wire logic [pcbp_pkg::WORD_W-1:0]       i_wr_word,
    input  wire logic [pcbp_pkg::LEN_W-1:0]        i_wr_len,
    input  wire logic                              i_rd_en,
    input  wire logic [$clog2(SYMBOL_COUNT)-1:0]   i_rd_addr,
    output logic      [MAX_CODE_LEN-1:0]           o_rd_word,
    output logic      [$clog2(MAX_CODE_LEN+1)-1:0] o_rd_len
);

    localparam int CW = MAX_CODE_LEN;
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int EW = CW + LW;

    logic [EW-1:0]              r_mem [SYMBOL_COUNT];
    logic [EW-1:0]              r_rd;
    logic [pcbp_pkg::LEN_W-1:0] len_sat;
    logic [CW-1:0]              word_masked;

    // saturate overlong lengths, drop code bits above the length
    always_comb begin
        if (i_wr_len > pcbp_pkg::LEN_W'(MAX_CODE_LEN)) begin
            len_sat = pcbp_pkg::LEN_W'(MAX_CODE_LEN);
        end else begin
            len_sat = i_wr_len;
        end
        word_masked = CW'(i_wr_word) & ~({CW{1'b1}} << len_sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {LW'(len_sat), word_masked};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_word = r_rd[CW-1:0];
    assign o_rd_len  = r_rd[EW-1:CW];

endmodule

`default_nettype wire

// ===== design/pcbp_pack.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcbp_pack #(
    parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_accept,
    input  wire pcbp_pkg::t_cmd                            i_cmd,
    input  wire logic                                      i_hit,
    input  wire logic [MAX_CODE_LEN-1:0]                   i_code_word,
    input  wire logic [$clog2(MAX_CODE_LEN+1)-1:0]         i_code_len,
    input  wire logic                                      i_emit_free,
    output logic                                           o_ready,
    output logic                                           o_busy,
    output pcbp_pkg::t_emit_req                            o_emit,
    output logic      [((MAX_CODE_LEN+7)/8)*8-1:0]         o_emit_data
);

    localparam int CW    = MAX_CODE_LEN;
    localparam int SW    = CW + pcbp_pkg::ACC_W;
    localparam int MAXB  = SW / 8;
    localparam int BW    = MAXB * 8;
    localparam int LSW   = $clog2(SW + 1);
    localparam int SHW   = $clog2(BW + 1);
    localparam int ACC_W = pcbp_pkg::ACC_W;
    localparam int CNT_W = pcbp_pkg::CNT_W;

    logic                  r_valid;
    pcbp_pkg::t_cmd        r_cmd;
    logic                  r_hit;
    logic [ACC_W-1:0]      r_acc;
    logic [2:0]            r_pend;

    logic [ACC_W-1:0]      n_acc;
    logic [2:0]            n_pend;

    logic [LSW-1:0]        bit_sum;
    logic [CNT_W-1:0]      enc_cnt;
    logic [CNT_W-1:0]      free_slots;
    logic [SHW-1:0]        align_sh;
    logic [SW-1:0]         merged;
    logic [SW-1:0]         merged_hi;
    logic [BW-1:0]         enc_data;
    logic [ACC_W-1:0]      enc_acc;
    logic [pcbp_pkg::BYTE_W-1:0] fl_byte;
    logic [BW-1:0]         fl_data;
    logic                  has_out;
    logic [CNT_W-1:0]      out_cnt;
    logic [BW-1:0]         out_data;
    logic                  adv;

    always_comb begin
        bit_sum    = LSW'(r_pend) + LSW'(i_code_len);
        enc_cnt    = CNT_W'(bit_sum >> 3);
        merged     = (SW'(r_acc) << i_code_len) | SW'(i_code_word);
        merged_hi  = merged >> bit_sum[2:0];
        free_slots = CNT_W'(MAXB) - enc_cnt;
        align_sh   = SHW'({free_slots, 3'b000});
        enc_data   = BW'(merged_hi) << align_sh;
        enc_acc    = merged[ACC_W-1:0] & ~({ACC_W{1'b1}} << bit_sum[2:0]);
        fl_byte    = pcbp_pkg::BYTE_W'({1'b0, r_acc} << (4'd8 - {1'b0, r_pend}));
        fl_data    = BW'(fl_byte) << (BW - pcbp_pkg::BYTE_W);

        has_out  = 1'b0;
        out_cnt  = enc_cnt;
        out_data = enc_data;
        n_acc    = r_acc;
        n_pend   = r_pend;
        case (r_cmd)
            pcbp_pkg::CMD_ENCODE: begin
                if (r_hit) begin
                    has_out = (enc_cnt != '0);
                    n_acc   = enc_acc;
                    n_pend  = bit_sum[2:0];
                end
            end
            pcbp_pkg::CMD_FLUSH: begin
                has_out  = (r_pend != '0);
                out_cnt  = CNT_W'(1);
                out_data = fl_data;
                n_acc    = '0;
                n_pend   = '0;
            end
            default: begin
            end
        endcase

        adv = r_valid && (!has_out || i_emit_free);
    end

    assign o_ready      = !r_valid || adv;
    assign o_busy       = r_valid;
    assign o_emit.load  = adv && has_out;
    assign o_emit.count = out_cnt;
    assign o_emit_data  = out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_pend  <= '0;
        end else begin
            if (i_accept) begin
                r_valid <= 1'b1;
            end else if (adv) begin
                r_valid <= 1'b0;
            end
            if (adv) begin
                r_acc  <= n_acc;
                r_pend <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= i_cmd;
            r_hit <= i_hit;
        end
    end

endmodule

`default_nettype wire

// ===== design/pcbp_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcbp_emit #(
    parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire pcbp_pkg::t_emit_req               i_req,
    input  wire logic [((MAX_CODE_LEN+7)/8)*8-1:0] i_data,
    input  wire logic                              i_tready,
    output logic                                   o_tvalid,
    output logic      [pcbp_pkg::BYTE_W-1:0]       o_tdata,
    output logic                                   o_tlast,
    output logic                                   o_free
);

    localparam int BW    = ((MAX_CODE_LEN + 7) / 8) * 8;
    localparam int CNT_W = pcbp_pkg::CNT_W;

    logic [BW-1:0]    r_buf;
    logic [CNT_W-1:0] r_cnt;
    logic             xfer;

    assign xfer     = (r_cnt != '0) && i_tready;
    assign o_free   = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_tready);
    assign o_tvalid = (r_cnt != '0);
    assign o_tdata  = r_buf[BW-1 -: pcbp_pkg::BYTE_W];
    assign o_tlast  = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.load) begin
            r_cnt <= i_req.count;
        end else if (xfer) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // advance one byte per transfer, MSB first
    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_buf <= i_data;
        end else if (xfer) begin
            r_buf <= r_buf << pcbp_pkg::BYTE_W;
        end
    end

endmodule

`default_nettype wire

// ===== design/prefix_code_bit_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: command; tdata: symbol, code_word, code_length
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: packed_byte; tlast: last_of_run
//
// One item is taken per cycle unless the packer stage is stalled; the code table read is
// registered with the item in the packer stage, which loads the output register. A k-byte encode
// (k up to 4) sends a byte per cycle while m_axis_tready is high; items without bytes pass freely.
// Reset clears the bit accumulator and the pipeline; the code table is not cleared.
// A stalled output holds the packer stage, which in turn deasserts s_axis_tready.

module prefix_code_bit_packer #(
    parameter int SYMBOL_COUNT = pcbp_pkg::SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] symbol, [39:8] code_word, [45:40] code_length, [47:46] zero
    input  wire logic [pcbp_pkg::TDATA_W-1:0]   s_axis_tdata,
    // [1:0] command
    input  wire logic [pcbp_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] packed_byte
    output logic      [pcbp_pkg::BYTE_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int AW = $clog2(SYMBOL_COUNT);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int BW = ((MAX_CODE_LEN + 7) / 8) * 8;

    pcbp_pkg::t_cmd               cmd;
    logic [pcbp_pkg::SYM_W-1:0]   sym;
    logic [pcbp_pkg::WORD_W-1:0]  word;
    logic [pcbp_pkg::LEN_W-1:0]   len;
    logic                         hit;
    logic                         accept;
    logic [MAX_CODE_LEN-1:0]      rd_word;
    logic [LW-1:0]                rd_len;
    logic                         emit_free;
    logic                         pack_busy;
    pcbp_pkg::t_emit_req          emit_req;
    logic [BW-1:0]                emit_data;

    assign cmd    = pcbp_pkg::t_cmd'(s_axis_tuser);
    assign sym    = s_axis_tdata[7:0];
    assign word   = s_axis_tdata[39:8];
    assign len    = s_axis_tdata[45:40];
    assign hit    = ({1'b0, sym} < 9'(SYMBOL_COUNT));
    assign accept = s_axis_tvalid && s_axis_tready;

    pcbp_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (cmd == pcbp_pkg::CMD_LOAD) && hit),
        .i_wr_addr (sym[AW-1:0]),
        .i_wr_word (word),
        .i_wr_len  (len),
        .i_rd_en   (accept && (cmd == pcbp_pkg::CMD_ENCODE) && hit),
        .i_rd_addr (sym[AW-1:0]),
        .o_rd_word (rd_word),
        .o_rd_len  (rd_len)
    );

    pcbp_pack #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (cmd),
        .i_hit       (hit),
        .i_code_word (rd_word),
        .i_code_len  (rd_len),
        .i_emit_free (emit_free),
        .o_ready     (s_axis_tready),
        .o_busy      (pack_busy),
        .o_emit      (emit_req),
        .o_emit_data (emit_data)
    );

    pcbp_emit #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (emit_req),
        .i_data   (emit_data),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_free   (emit_free)
    );

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_req.load |-> emit_free)
        else $error("output buffer overwritten while bytes remain");

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside a run of output bytes");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> pack_busy)
        else $error("accepted item lost before packing");

endmodule

`default_nettype wire
